### rtl/core/circular_doubly_linked_list_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define CLLDL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLLDL_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/clldl_pkg.sv
package clldl_pkg;

  localparam int NODE_COUNT = 16;
  localparam int IDX_W      = $clog2(NODE_COUNT + 1);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int DATA_W     = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;

  // header sentinel index
  localparam idx_t HDR = idx_t'(NODE_COUNT);

  typedef enum logic [2:0] {
    REQ_INS_FIRST = 3'd0,
    REQ_INS_LAST  = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_DEL_FIRST = 3'd3,
    REQ_DEL_LAST  = 3'd4,
    REQ_SEARCH    = 3'd5,
    REQ_COUNT     = 3'd6,
    REQ_TRAVERSE  = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_BAD_POS   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_GETP,
    ST_INS_GETQ,
    ST_INS_GETF,
    ST_INS_LINK,
    ST_DEL_GETN,
    ST_DEL_GETL,
    ST_DEL_FREE,
    ST_WALK_START,
    ST_WALK_CHK
  } state_t;

  // reset contents of the forward links: header self-linked, free nodes chained
  function automatic idx_t next_reset_val(idx_t i);
    return (i == HDR) ? HDR : idx_t'(i + idx_t'(1));
  endfunction

  // reset contents of the back links: header self-linked
  function automatic idx_t prev_reset_val(idx_t i);
    return (i == HDR) ? HDR : '0;
  endfunction

endpackage

### rtl/core/clldl_ram.sv
module clldl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/circular_doubly_linked_list_engine.sv
// Node-pool engine for a circular doubly linked list with a header sentinel
// and a free list. One request is taken at a time; in_ready is high only
// while the engine is idle. Search and traverse visit at most 16 nodes;
// the walk follows one forward link per cycle (a traverse step waits while
// a result is pending and out_ready is low) through the single read port
// of the link memory. Traverse gives one transaction per element, the last
// one flagged; any state that emits a result waits while a result is
// pending and out_ready is low. A finished result sits in an output
// register, so the next request can be accepted while it waits.
module circular_doubly_linked_list_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_req_type,
  input  logic signed [clldl_pkg::DATA_W-1:0] in_item_value,
  input  logic [clldl_pkg::IDX_W-1:0]       in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [clldl_pkg::IDX_W-1:0]       out_node_index,
  output logic signed [clldl_pkg::DATA_W-1:0] out_data_value,
  output logic [clldl_pkg::IDX_W-1:0]       out_element_total,
  output logic                              out_last
);

  localparam int NC     = clldl_pkg::NODE_COUNT;
  localparam int IDX_W  = clldl_pkg::IDX_W;
  localparam int NODE_W = clldl_pkg::NODE_W;
  localparam int DATA_W = clldl_pkg::DATA_W;

  clldl_pkg::state_t state_r, state_nxt;
  clldl_pkg::req_t   req_r, req_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  clldl_pkg::idx_t   pos_r, pos_nxt;
  clldl_pkg::idx_t   p_r, p_nxt;
  clldl_pkg::idx_t   q_r, q_nxt;
  clldl_pkg::idx_t   node_r, node_nxt;
  clldl_pkg::idx_t   fnext_r, fnext_nxt;
  clldl_pkg::idx_t   steps_r, steps_nxt;
  clldl_pkg::idx_t   free_head_r, free_head_nxt;
  clldl_pkg::idx_t   count_r, count_nxt;
  logic [NC-1:0]     in_use_r, in_use_nxt;
  logic [NC:0]       next_vld_r, prev_vld_r;

  // link memory read bookkeeping for the reset-value substitution
  clldl_pkg::idx_t   next_ra_r, prev_ra_r;
  logic              next_rv_r, prev_rv_r;

  logic              out_valid_r;
  clldl_pkg::status_t out_status_r;
  clldl_pkg::idx_t   out_node_r, out_total_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;

  // memory ports
  logic              next_re, next_we, prev_re, prev_we, val_re, val_we;
  clldl_pkg::idx_t   next_raddr, next_waddr, next_wdata, next_rdata;
  clldl_pkg::idx_t   prev_raddr, prev_waddr, prev_wdata, prev_rdata;
  logic [NODE_W-1:0] val_raddr, val_waddr;
  logic [DATA_W-1:0] val_wdata, val_rdata;

  clldl_pkg::idx_t   next_d, prev_d, cur, del_node, ins_p, steps1;
  logic              out_free, pos_ok, end_walk;

  logic              emit;
  clldl_pkg::status_t e_status;
  clldl_pkg::idx_t   e_node, e_total;
  logic [DATA_W-1:0] e_data;
  logic              e_last;

  clldl_ram #(.WIDTH(IDX_W), .DEPTH(NC + 1)) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_waddr),
    .wr_data (next_wdata),
    .rd_en   (next_re),
    .rd_addr (next_raddr),
    .rd_data (next_rdata)
  );

  clldl_ram #(.WIDTH(IDX_W), .DEPTH(NC + 1)) u_prev_ram (
    .clk     (clk),
    .wr_en   (prev_we),
    .wr_addr (prev_waddr),
    .wr_data (prev_wdata),
    .rd_en   (prev_re),
    .rd_addr (prev_raddr),
    .rd_data (prev_rdata)
  );

  clldl_ram #(.WIDTH(DATA_W), .DEPTH(NC)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_wdata),
    .rd_en   (val_re),
    .rd_addr (val_raddr),
    .rd_data (val_rdata)
  );

  assign next_d = next_rv_r ? next_rdata : clldl_pkg::next_reset_val(next_ra_r);
  assign prev_d = prev_rv_r ? prev_rdata : clldl_pkg::prev_reset_val(prev_ra_r);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == clldl_pkg::ST_IDLE);
  assign pos_ok   = (pos_r == clldl_pkg::HDR) ||
                    ((pos_r < clldl_pkg::HDR) && in_use_r[pos_r[NODE_W-1:0]]);
  assign ins_p    = (req_r == clldl_pkg::REQ_INS_FIRST) ? clldl_pkg::HDR : pos_r;
  assign del_node = (req_r == clldl_pkg::REQ_DEL_FIRST) ? next_d : prev_d;
  assign cur      = next_d;
  assign steps1   = clldl_pkg::idx_t'(steps_r + clldl_pkg::idx_t'(1));
  assign end_walk = (cur == clldl_pkg::HDR) || (steps1 == clldl_pkg::idx_t'(NC));

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    node_nxt      = node_r;
    fnext_nxt     = fnext_r;
    steps_nxt     = steps_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    in_use_nxt    = in_use_r;

    next_re    = 1'b0;
    next_raddr = clldl_pkg::HDR;
    next_we    = 1'b0;
    next_waddr = node_r;
    next_wdata = q_r;
    prev_re    = 1'b0;
    prev_raddr = clldl_pkg::HDR;
    prev_we    = 1'b0;
    prev_waddr = node_r;
    prev_wdata = p_r;
    val_re     = 1'b0;
    val_raddr  = cur[NODE_W-1:0];
    val_we     = 1'b0;
    val_waddr  = node_r[NODE_W-1:0];
    val_wdata  = val_r;

    emit     = 1'b0;
    e_status = clldl_pkg::STS_OK;
    e_node   = clldl_pkg::HDR;
    e_data   = '0;
    e_total  = count_r;
    e_last   = 1'b1;

    unique case (state_r)
      clldl_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = clldl_pkg::req_t'(in_req_type);
          val_nxt   = in_item_value;
          pos_nxt   = in_position;
          state_nxt = clldl_pkg::ST_DECODE;
        end
      end

      clldl_pkg::ST_DECODE: begin
        unique case (req_r)
          clldl_pkg::REQ_INS_FIRST, clldl_pkg::REQ_INS_LAST,
          clldl_pkg::REQ_INS_AFTER: begin
            node_nxt = free_head_r;
            if (free_head_r == clldl_pkg::HDR) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = clldl_pkg::STS_FULL;
                state_nxt = clldl_pkg::ST_IDLE;
              end
            end else if (req_r == clldl_pkg::REQ_INS_LAST) begin
              prev_re   = 1'b1;
              state_nxt = clldl_pkg::ST_INS_GETP;
            end else if (req_r == clldl_pkg::REQ_INS_FIRST || pos_ok) begin
              p_nxt      = ins_p;
              next_re    = 1'b1;
              next_raddr = ins_p;
              state_nxt  = clldl_pkg::ST_INS_GETQ;
            end else if (out_free) begin
              emit      = 1'b1;
              e_status  = clldl_pkg::STS_BAD_POS;
              state_nxt = clldl_pkg::ST_IDLE;
            end
          end
          clldl_pkg::REQ_DEL_FIRST, clldl_pkg::REQ_DEL_LAST: begin
            if (count_r == '0) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = clldl_pkg::STS_EMPTY;
                state_nxt = clldl_pkg::ST_IDLE;
              end
            end else begin
              next_re   = (req_r == clldl_pkg::REQ_DEL_FIRST);
              prev_re   = (req_r == clldl_pkg::REQ_DEL_LAST);
              state_nxt = clldl_pkg::ST_DEL_GETN;
            end
          end
          clldl_pkg::REQ_SEARCH, clldl_pkg::REQ_TRAVERSE: begin
            if (req_r == clldl_pkg::REQ_TRAVERSE && count_r == '0) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = clldl_pkg::STS_EMPTY;
                state_nxt = clldl_pkg::ST_IDLE;
              end
            end else begin
              next_re   = 1'b1;
              steps_nxt = '0;
              state_nxt = clldl_pkg::ST_WALK_START;
            end
          end
          clldl_pkg::REQ_COUNT: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = clldl_pkg::ST_IDLE;
            end
          end
        endcase
      end

      clldl_pkg::ST_INS_GETP: begin
        p_nxt      = prev_d;
        next_re    = 1'b1;
        next_raddr = prev_d;
        state_nxt  = clldl_pkg::ST_INS_GETQ;
      end

      clldl_pkg::ST_INS_GETQ: begin
        q_nxt      = next_d;
        next_re    = 1'b1;
        next_raddr = node_r;
        state_nxt  = clldl_pkg::ST_INS_GETF;
      end

      clldl_pkg::ST_INS_GETF: begin
        // new node: next = q, prev = p, value stored
        fnext_nxt = next_d;
        next_we   = 1'b1;
        prev_we   = 1'b1;
        val_we    = 1'b1;
        state_nxt = clldl_pkg::ST_INS_LINK;
      end

      clldl_pkg::ST_INS_LINK: begin
        if (out_free) begin
          next_we    = 1'b1;
          next_waddr = p_r;
          next_wdata = node_r;
          prev_we    = 1'b1;
          prev_waddr = q_r;
          prev_wdata = node_r;
          in_use_nxt[node_r[NODE_W-1:0]] = 1'b1;
          count_nxt     = clldl_pkg::idx_t'(count_r + clldl_pkg::idx_t'(1));
          free_head_nxt = fnext_r;
          emit      = 1'b1;
          e_node    = node_r;
          e_data    = val_r;
          e_total   = clldl_pkg::idx_t'(count_r + clldl_pkg::idx_t'(1));
          state_nxt = clldl_pkg::ST_IDLE;
        end
      end

      clldl_pkg::ST_DEL_GETN: begin
        node_nxt = del_node;
        if (del_node == clldl_pkg::HDR) begin
          if (out_free) begin
            emit      = 1'b1;
            e_status  = clldl_pkg::STS_EMPTY;
            state_nxt = clldl_pkg::ST_IDLE;
          end
        end else begin
          next_re    = 1'b1;
          next_raddr = del_node;
          prev_re    = 1'b1;
          prev_raddr = del_node;
          val_re     = 1'b1;
          val_raddr  = del_node[NODE_W-1:0];
          state_nxt  = clldl_pkg::ST_DEL_GETL;
        end
      end

      clldl_pkg::ST_DEL_GETL: begin
        // bridge the neighbours across the removed node
        next_we    = 1'b1;
        next_waddr = prev_d;
        next_wdata = next_d;
        prev_we    = 1'b1;
        prev_waddr = next_d;
        prev_wdata = prev_d;
        state_nxt  = clldl_pkg::ST_DEL_FREE;
      end

      clldl_pkg::ST_DEL_FREE: begin
        if (out_free) begin
          next_we    = 1'b1;
          next_waddr = node_r;
          next_wdata = free_head_r;
          in_use_nxt[node_r[NODE_W-1:0]] = 1'b0;
          free_head_nxt = node_r;
          count_nxt     = clldl_pkg::idx_t'(count_r - clldl_pkg::idx_t'(1));
          emit      = 1'b1;
          e_node    = node_r;
          e_data    = val_rdata;
          e_total   = clldl_pkg::idx_t'(count_r - clldl_pkg::idx_t'(1));
          state_nxt = clldl_pkg::ST_IDLE;
        end
      end

      clldl_pkg::ST_WALK_START: begin
        if (cur == clldl_pkg::HDR) begin
          if (out_free) begin
            emit      = 1'b1;
            e_status  = (req_r == clldl_pkg::REQ_SEARCH) ? clldl_pkg::STS_NOT_FOUND
                                                         : clldl_pkg::STS_EMPTY;
            state_nxt = clldl_pkg::ST_IDLE;
          end
        end else begin
          node_nxt   = cur;
          next_re    = 1'b1;
          next_raddr = cur;
          val_re     = 1'b1;
          state_nxt  = clldl_pkg::ST_WALK_CHK;
        end
      end

      clldl_pkg::ST_WALK_CHK: begin
        // node_r's value and forward link are on the memory outputs
        if (req_r == clldl_pkg::REQ_SEARCH) begin
          if (val_rdata == val_r) begin
            if (out_free) begin
              emit      = 1'b1;
              e_node    = node_r;
              e_data    = val_r;
              state_nxt = clldl_pkg::ST_IDLE;
            end
          end else if (end_walk) begin
            if (out_free) begin
              emit      = 1'b1;
              e_status  = clldl_pkg::STS_NOT_FOUND;
              state_nxt = clldl_pkg::ST_IDLE;
            end
          end else begin
            steps_nxt  = steps1;
            node_nxt   = cur;
            next_re    = 1'b1;
            next_raddr = cur;
            val_re     = 1'b1;
          end
        end else if (out_free) begin
          emit   = 1'b1;
          e_node = node_r;
          e_data = val_rdata;
          e_last = end_walk;
          if (end_walk) begin
            state_nxt = clldl_pkg::ST_IDLE;
          end else begin
            steps_nxt  = steps1;
            node_nxt   = cur;
            next_re    = 1'b1;
            next_raddr = cur;
            val_re     = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = clldl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clldl_pkg::ST_IDLE;
      free_head_r <= '0;
      count_r     <= '0;
      in_use_r    <= '0;
      next_vld_r  <= '0;
      prev_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      if (next_we) begin
        next_vld_r[next_waddr] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld_r[prev_waddr] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    node_r  <= node_nxt;
    fnext_r <= fnext_nxt;
    steps_r <= steps_nxt;
    if (next_re) begin
      next_ra_r <= next_raddr;
      next_rv_r <= next_vld_r[next_raddr];
    end
    if (prev_re) begin
      prev_ra_r <= prev_raddr;
      prev_rv_r <= prev_vld_r[prev_raddr];
    end
    if (emit) begin
      out_status_r <= e_status;
      out_node_r   <= e_node;
      out_data_r   <= e_data;
      out_total_r  <= e_total;
      out_last_r   <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_node_index    = out_node_r;
  assign out_data_value    = out_data_r;
  assign out_element_total = out_total_r;
  assign out_last          = out_last_r;

endmodule

### rtl/core/clldl_checker.sv
`include "circular_doubly_linked_list_engine_defines.svh"

module clldl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [2:0]                          out_status,
  input logic [clldl_pkg::IDX_W-1:0]         out_node_index,
  input logic signed [clldl_pkg::DATA_W-1:0] out_data_value,
  input logic [clldl_pkg::IDX_W-1:0]         out_element_total,
  input logic                                out_last
);

  // a stalled result holds
  `CLLDL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data_value) && $stable(out_node_index) && $stable(out_last), "stalled result changed")

  // one request at a time: busy right after a transaction is taken
  `CLLDL_ASSERT_NXT(a_one_req, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")

  // a failed request names no node and ends the request
  `CLLDL_ASSERT_IMP(a_err_shape, clk, rst_n, out_valid && (out_status != 3'(clldl_pkg::STS_OK)), (out_node_index == clldl_pkg::HDR) && out_last && (out_data_value == '0), "error result malformed")

  // element total never exceeds the pool
  `CLLDL_ASSERT_IMP(a_total_range, clk, rst_n, out_valid, out_element_total <= clldl_pkg::HDR, "element total out of range")

endmodule

bind circular_doubly_linked_list_engine clldl_checker u_clldl_checker (.*);
